>>> design/dmpu_pkg.sv
// Shared widths, constants and sideband type for the point undistortion pipeline.
package dmpu_pkg;

	localparam int CW   = 32;
	localparam int FB   = 24;
	localparam int DW   = ((3 * CW > 3 * FB) ? 3 * CW : 3 * FB) + 2;
	localparam int RW   = DW + FB;
	localparam int RADW = RW + (RW % 2);
	localparam int QW   = RADW / 2;
	localparam int EW   = ((QW > 2 * FB + 1) ? QW : 2 * FB + 1) + 1;
	localparam int DDW  = EW + 1;
	localparam int QDW  = CW + 1;
	localparam int NW   = ((CW + 2 * FB + 2 > EW) ? CW + 2 * FB + 2 : EW) + 1;

	localparam logic [DW-1:0] M_ONE = DW'(1) << (3 * FB);
	localparam logic [EW-1:0] E_ONE = EW'(1) << (2 * FB);

	typedef struct packed {
		logic          byp;
		logic          inv;
		logic [CW-1:0] xr;
		logic [CW-1:0] yr;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
	} side_t;

endpackage

>>> design/dmpu_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
module dmpu_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dmpu_pkg::RADW-1:0] rad,
	output logic [dmpu_pkg::QW-1:0]   root
);
	import dmpu_pkg::*;

	logic [RADW-1:0] rad_s  [QW];
	logic [QW:0]     rem_s  [QW];
	logic [QW-1:0]   root_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RADW-1:0] rad_i;
		logic [QW:0]     rem_i;
		logic [QW-1:0]   root_i;
		logic [QW+2:0]   rem_x;
		logic [QW+2:0]   trial;
		logic [QW+2:0]   diff;

		if (k == 0) begin : g_first
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end

		assign rem_x = {rem_i, rad_i[RADW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign diff  = rem_x - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {rad_i[RADW-3:0], 2'b00};
				if (rem_x >= trial) begin
					rem_s[k]  <= diff[QW:0];
					root_s[k] <= {root_i[QW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_x[QW:0];
					root_s[k] <= {root_i[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[QW-1];

endmodule

>>> design/dmpu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dmpu_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [dmpu_pkg::NW-1:0]  num,
	input  logic [dmpu_pkg::DDW-1:0] den,
	output logic [dmpu_pkg::QDW-1:0] quo
);
	import dmpu_pkg::*;

	logic [NW+DDW-1:0] num_ext;
	logic [DDW-1:0]    rem_s [QDW];
	logic [QDW-1:0]    low_s [QDW];
	logic [QDW-1:0]    quo_s [QDW];
	logic [DDW-1:0]    den_s [QDW];

	assign num_ext = {{DDW{1'b0}}, num};

	for (genvar k = 0; k < QDW; k++) begin : g_stage
		logic [DDW-1:0] rem_i;
		logic [QDW-1:0] low_i;
		logic [QDW-1:0] quo_i;
		logic [DDW-1:0] den_i;
		logic [DDW:0]   rx;
		logic [DDW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_i = num_ext[QDW +: DDW];
			assign low_i = num_ext[QDW-1:0];
			assign quo_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign quo_i = quo_s[k-1];
			assign den_i = den_s[k-1];
		end

		assign rx   = {rem_i, low_i[QDW-1]};
		assign diff = rx - {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_i;
				low_s[k] <= {low_i[QDW-2:0], 1'b0};
				if (rx >= {1'b0, den_i}) begin
					rem_s[k] <= diff[DDW-1:0];
					quo_s[k] <= {quo_i[QDW-2:0], 1'b1};
				end else begin
					rem_s[k] <= rx[DDW-1:0];
					quo_s[k] <= {quo_i[QDW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[QDW-1];

endmodule

>>> design/division_model_point_undistort.sv
// Top level: inverse one-parameter division lens model, one point per clock unless the output stalls.
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+------------------------
//  input    | x_in, y_in                       | in_valid / in_ready
//  output   | x_out, y_out, invalid            | out_valid / out_ready
//  config   | lambda_wdata                     | lambda_we, no wait
//
// One transaction per clock sustained while the output does not stall, at 32-bit
// Q8.24; the pipeline depth is set by the one-bit-per-stage square root and divider.
// Reset clears all valid bits and lambda; payload registers are not reset.
// A stall on the output freezes every stage at once; in_ready is low only
// while a result waits and out_ready is low.
module division_model_point_undistort (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [dmpu_pkg::CW-1:0] x_in,
	input  logic [dmpu_pkg::CW-1:0] y_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [dmpu_pkg::CW-1:0] x_out,
	output logic [dmpu_pkg::CW-1:0] y_out,
	output logic                    invalid,
	input  logic                    lambda_we,
	input  logic [dmpu_pkg::CW-1:0] lambda_wdata
);
	import dmpu_pkg::*;

	logic            en;
	logic [CW-1:0]   lambda_q;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_se;
	side_t           sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_se;
	logic [CW-1:0]   al_s1, al_s2, al_s3;
	logic            ln_s1, ln_s2, ln_s3, ln_s4, ln_s5;
	logic [2*CW-1:0] sqx_s2, sqy_s2;
	logic [2*CW-1:0] s_s3;
	logic [2*CW-1:0] plo_s4, phi_s4;
	logic [DW-1:0]   t_s5;
	logic [RADW-1:0] rad_s6;
	logic [NW-1:0]   numx_se, numy_se;
	logic [DDW-1:0]  den_se;

	logic            va_q [QW];
	side_t           sa_q [QW];
	logic            vb_q [QDW];
	side_t           sb_q [QDW];

	logic [CW-1:0]   ax_c, ay_c, al_c;
	logic [3*CW-1:0] p_c;
	logic [DW-1:0]   dn_c;
	logic            inv_c;
	logic [QW-1:0]   root;
	logic [EW-1:0]   e_c;
	logic [QDW-1:0]  qx, qy;
	side_t           sd_o;

	logic            vo_q;
	logic [CW-1:0]   xo_q, yo_q;
	logic            invo_q;

	assign en        = !vo_q || out_ready;
	assign in_ready  = en;
	assign out_valid = vo_q;
	assign x_out     = xo_q;
	assign y_out     = yo_q;
	assign invalid   = invo_q;

	function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
		mag = v[CW-1] ? (~v + CW'(1)) : v;
	endfunction

	function automatic logic [CW-1:0] sat(input logic [QDW-1:0] q, input logic neg);
		logic [QDW-1:0] lim;
		logic [QDW-1:0] m;
		lim = (QDW'(1) << (CW - 1)) - (neg ? QDW'(0) : QDW'(1));
		m   = (q > lim) ? lim : q;
		sat = neg ? (~m[CW-1:0] + CW'(1)) : m[CW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
		end else if (lambda_we) begin
			lambda_q <= lambda_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_se <= 1'b0;
			vo_q <= 1'b0;
			for (int i = 0; i < QW; i++) va_q[i] <= 1'b0;
			for (int i = 0; i < QDW; i++) vb_q[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			va_q[0] <= v_s6;
			for (int i = 1; i < QW; i++) va_q[i] <= va_q[i-1];
			v_se <= va_q[QW-1];
			vb_q[0] <= v_se;
			for (int i = 1; i < QDW; i++) vb_q[i] <= vb_q[i-1];
			vo_q <= vb_q[QDW-1];
		end
	end

	assign ax_c = mag(x_in);
	assign ay_c = mag(y_in);
	assign al_c = mag(lambda_q);
	assign p_c  = {{CW{1'b0}}, plo_s4} + {phi_s4, {CW{1'b0}}};

	always_comb begin
		inv_c = 1'b0;
		if (ln_s5) begin
			dn_c = M_ONE + t_s5;
		end else begin
			inv_c = t_s5 > M_ONE;
			dn_c  = M_ONE - t_s5;
		end
	end

	assign e_c = E_ONE + EW'(root);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.byp <= (lambda_q == '0) || (x_in == '0 && y_in == '0);
			sd_s1.inv <= 1'b0;
			sd_s1.xr  <= x_in;
			sd_s1.yr  <= y_in;
			sd_s1.ax  <= ax_c;
			sd_s1.ay  <= ay_c;
			al_s1     <= al_c;
			ln_s1     <= lambda_q[CW-1];

			sd_s2  <= sd_s1;
			al_s2  <= al_s1;
			ln_s2  <= ln_s1;
			sqx_s2 <= sd_s1.ax * sd_s1.ax;
			sqy_s2 <= sd_s1.ay * sd_s1.ay;

			sd_s3 <= sd_s2;
			al_s3 <= al_s2;
			ln_s3 <= ln_s2;
			s_s3  <= sqx_s2 + sqy_s2;

			sd_s4  <= sd_s3;
			ln_s4  <= ln_s3;
			plo_s4 <= al_s3 * s_s3[CW-1:0];
			phi_s4 <= al_s3 * s_s3[2*CW-1:CW];

			sd_s5 <= sd_s4;
			ln_s5 <= ln_s4;
			t_s5  <= DW'({p_c, 2'b00});

			sd_s6.byp <= sd_s5.byp;
			sd_s6.inv <= inv_c;
			sd_s6.xr  <= sd_s5.xr;
			sd_s6.yr  <= sd_s5.yr;
			sd_s6.ax  <= sd_s5.ax;
			sd_s6.ay  <= sd_s5.ay;
			rad_s6    <= inv_c ? '0 : RADW'({dn_c, {FB{1'b0}}});

			sa_q[0] <= sd_s6;
			for (int i = 1; i < QW; i++) sa_q[i] <= sa_q[i-1];

			sd_se   <= sa_q[QW-1];
			numx_se <= NW'({sa_q[QW-1].ax, {(2 * FB + 2){1'b0}}}) + NW'(e_c);
			numy_se <= NW'({sa_q[QW-1].ay, {(2 * FB + 2){1'b0}}}) + NW'(e_c);
			den_se  <= {e_c, 1'b0};

			sb_q[0] <= sd_se;
			for (int i = 1; i < QDW; i++) sb_q[i] <= sb_q[i-1];

			if (sd_o.byp) begin
				xo_q   <= sd_o.xr;
				yo_q   <= sd_o.yr;
				invo_q <= 1'b0;
			end else if (sd_o.inv) begin
				xo_q   <= '0;
				yo_q   <= '0;
				invo_q <= 1'b1;
			end else begin
				xo_q   <= sat(qx, sd_o.xr[CW-1]);
				yo_q   <= sat(qy, sd_o.yr[CW-1]);
				invo_q <= 1'b0;
			end
		end
	end

	assign sd_o = sb_q[QDW-1];

	dmpu_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s6),
		.root (root)
	);

	dmpu_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_se),
		.den (den_se),
		.quo (qx)
	);

	dmpu_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_se),
		.den (den_se),
		.quo (qy)
	);

`ifndef SYNTH
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> x_out == '0 && y_out == '0)
		else $error("invalid result carries nonzero coordinates");

	a_inv_not_byp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && sd_s6.inv |-> !sd_s6.byp)
		else $error("pass-through point flagged invalid");

	a_stall_root: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(root))
		else $error("square root pipeline moved during stall");
`endif

endmodule
